// ----- sv/fpla_pkg.sv -----
// ----------------------------------------------------------------------------
// fpla_pkg
// Shared widths, codes and controller/datapath link types of the allocator.
// ----------------------------------------------------------------------------
package fpla_pkg;

  localparam int unsigned FENCE_W   = 64;
  localparam int unsigned SIZE_W    = 21;
  localparam int unsigned OFF_W     = 20;
  localparam int unsigned PAGE_W    = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned MAX_PAGES = 64;
  localparam int unsigned PAGE_BYTES = 1048576;
  localparam int unsigned ALIGN_W   = SIZE_W + 1;

  localparam logic CMD_RESERVE = 1'b0;
  localparam logic CMD_FREE    = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NO_PAGE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RSV,
    S_FREE
  } state_e;

  typedef struct packed {
    logic load;
    logic rsv_go;
    logic walk;
    logic free_go;
  } fpla_cmd_t;

  typedef struct packed {
    logic is_free;
    logic walk_done;
    logic out_room;
  } fpla_sts_t;

endpackage

// ----- sv/fpla_if.sv -----
// ----------------------------------------------------------------------------
// fpla_req_if / fpla_rsp_if
// Valid/ready channels for allocator commands and results.
// ----------------------------------------------------------------------------
interface fpla_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [fpla_pkg::FENCE_W-1:0]  fence_value;
  logic [fpla_pkg::SIZE_W-1:0]   request_size;
  logic [fpla_pkg::SIZE_W-1:0]   align_bytes;

  modport source (output valid, cmd, fence_value, request_size, align_bytes,
                  input ready);
  modport sink   (input valid, cmd, fence_value, request_size, align_bytes,
                  output ready);
endinterface

interface fpla_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [fpla_pkg::PAGE_W-1:0]   page_index;
  logic [fpla_pkg::OFF_W-1:0]    byte_offset;
  logic                          new_page;
  logic [fpla_pkg::CNT_W-1:0]    released_count;

  modport source (output valid, status, page_index, byte_offset, new_page,
                  released_count, input ready);
  modport sink   (input valid, status, page_index, byte_offset, new_page,
                  released_count, output ready);
endinterface

// ----- sv/fpla_ram.sv -----
// ----------------------------------------------------------------------------
// fpla_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fpla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fpla_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpla_ctrl
// Command sequencer: accept, reserve decision, free walk, result hand-off.
// ----------------------------------------------------------------------------
module fpla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fpla_pkg::fpla_sts_t sts_i,
  output fpla_pkg::fpla_cmd_t cmd_o
);
  import fpla_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
        end
      end
      S_RSV: begin
        if (sts_i.is_free) begin
          cmd_o.walk = 1'b1;
          state_d    = S_FREE;
        end else if (sts_i.out_room) begin
          cmd_o.rsv_go = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_FREE: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done && sts_i.out_room) begin
          cmd_o.free_go = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.load) begin
      state_d = S_RSV;
    end
  end

endmodule

// ----- sv/fpla_dp.sv -----
// ----------------------------------------------------------------------------
// fpla_dp
// Offset alignment, page selection, used-page list and retired-page FIFO.
// ----------------------------------------------------------------------------
module fpla_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fpla_pkg::fpla_cmd_t             cmd_i,
  output fpla_pkg::fpla_sts_t             sts_o,
  input  logic                            in_cmd_i,
  input  logic [fpla_pkg::FENCE_W-1:0]    in_fence_i,
  input  logic [fpla_pkg::SIZE_W-1:0]     in_size_i,
  input  logic [fpla_pkg::SIZE_W-1:0]     in_align_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      out_status_o,
  output logic [fpla_pkg::PAGE_W-1:0]     out_page_o,
  output logic [fpla_pkg::OFF_W-1:0]      out_offset_o,
  output logic                            out_new_o,
  output logic [fpla_pkg::CNT_W-1:0]      out_released_o
);
  import fpla_pkg::*;

  localparam logic [CNT_W-1:0]   MaxCnt   = CNT_W'(MAX_PAGES);
  localparam logic [ALIGN_W-1:0] PageLim  = ALIGN_W'(PAGE_BYTES);
  localparam logic [SIZE_W-1:0]  PageSize = SIZE_W'(PAGE_BYTES);

  // captured request
  logic               cmd_q;
  logic [FENCE_W-1:0] fence_q;
  logic [SIZE_W-1:0]  size_q;
  logic [SIZE_W-1:0]  align_q;

  // allocator state
  logic [SIZE_W-1:0]  offset_q, offset_d;
  logic [CNT_W-1:0]   used_cnt_q, used_cnt_d;
  logic [PAGE_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]   ret_cnt_q, ret_cnt_d;
  logic [CNT_W-1:0]   created_q, created_d;
  logic [PAGE_W-1:0]  last_pg_q, last_pg_d;

  // free walk
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               pend_q, pend_d;
  logic [CNT_W-1:0]   rel_q, rel_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q, out_status_d;
  logic [PAGE_W-1:0]  out_page_q, out_page_d;
  logic [OFF_W-1:0]   out_offset_q, out_offset_d;
  logic               out_new_q, out_new_d;
  logic [CNT_W-1:0]   out_rel_q, out_rel_d;

  // memories
  logic                       used_we;
  logic [PAGE_W-1:0]          used_rdata;
  logic                       ret_we;
  logic [PAGE_W-1:0]          ret_waddr;
  logic [FENCE_W+PAGE_W-1:0]  ret_rdata;
  logic [FENCE_W-1:0]         ret_fence;
  logic [PAGE_W-1:0]          ret_page;

  fpla_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_cnt_q[PAGE_W-1:0]),
    .wdata_i (last_pg_d),
    .raddr_i (rd_idx_q[PAGE_W-1:0]),
    .rdata_o (used_rdata)
  );

  fpla_ram #(.WIDTH(FENCE_W + PAGE_W), .DEPTH(MAX_PAGES)) u_retire_ram (
    .clk_i   (clk_i),
    .we_i    (ret_we),
    .waddr_i (ret_waddr),
    .wdata_i ({fence_q, used_rdata}),
    .raddr_i (head_q),
    .rdata_o (ret_rdata)
  );

  assign ret_fence = ret_rdata[FENCE_W+PAGE_W-1:PAGE_W];
  assign ret_page  = ret_rdata[PAGE_W-1:0];
  assign ret_waddr = head_q + ret_cnt_q[PAGE_W-1:0];

  // reserve decision
  logic [SIZE_W-1:0]  a_low, a_pow;
  logic [ALIGN_W-1:0] mask, aligned, fit_end;
  logic               too_large, need_page, recycle, no_page;
  logic [PAGE_W-1:0]  pick_pg;
  logic [OFF_W-1:0]   res_off;

  always_comb begin
    a_low     = align_q & (~align_q + SIZE_W'(1));
    a_pow     = (a_low == '0) ? SIZE_W'(1) : a_low;
    mask      = {1'b0, a_pow - SIZE_W'(1)};
    aligned   = ({1'b0, offset_q} + mask) & ~mask;
    fit_end   = aligned + {1'b0, size_q};
    too_large = size_q >= PageSize;
    need_page = (used_cnt_q == '0) || (aligned >= PageLim) || (fit_end > PageLim);
    recycle   = (ret_cnt_q != '0) && (ret_fence < fence_q);
    no_page   = need_page &&
                ((used_cnt_q >= MaxCnt) || (!recycle && (created_q >= MaxCnt)));
    pick_pg   = recycle ? ret_page : created_q[PAGE_W-1:0];
    res_off   = need_page ? '0 : aligned[OFF_W-1:0];
  end

  assign sts_o.is_free   = cmd_q;
  assign sts_o.walk_done = (rd_idx_q == used_cnt_q) && !pend_q;
  assign sts_o.out_room  = !out_valid_q || out_ready_i;

  always_comb begin
    offset_d     = offset_q;
    used_cnt_d   = used_cnt_q;
    head_d       = head_q;
    ret_cnt_d    = ret_cnt_q;
    created_d    = created_q;
    last_pg_d    = last_pg_q;
    rd_idx_d     = rd_idx_q;
    pend_d       = pend_q;
    rel_d        = rel_q;
    used_we      = 1'b0;
    ret_we       = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_page_d   = out_page_q;
    out_offset_d = out_offset_q;
    out_new_d    = out_new_q;
    out_rel_d    = out_rel_q;

    if (cmd_i.load) begin
      rd_idx_d = '0;
      pend_d   = 1'b0;
      rel_d    = '0;
    end

    if (cmd_i.walk) begin
      if (rd_idx_q < used_cnt_q) begin
        rd_idx_d = rd_idx_q + CNT_W'(1);
        pend_d   = 1'b1;
      end else begin
        pend_d   = 1'b0;
      end
      if (pend_q && (ret_cnt_q < MaxCnt)) begin
        ret_we    = 1'b1;
        ret_cnt_d = ret_cnt_q + CNT_W'(1);
        rel_d     = rel_q + CNT_W'(1);
      end
    end

    if (cmd_i.free_go) begin
      used_cnt_d   = '0;
      offset_d     = '0;
      out_valid_d  = 1'b1;
      out_status_d = STATUS_OK;
      out_page_d   = '0;
      out_offset_d = '0;
      out_new_d    = 1'b0;
      out_rel_d    = rel_q;
    end

    if (cmd_i.rsv_go) begin
      out_valid_d  = 1'b1;
      out_page_d   = '0;
      out_offset_d = '0;
      out_new_d    = 1'b0;
      out_rel_d    = '0;
      priority if (too_large) begin
        out_status_d = STATUS_TOO_LARGE;
      end else if (no_page) begin
        out_status_d = STATUS_NO_PAGE;
      end else begin
        out_status_d = STATUS_OK;
        if (need_page) begin
          last_pg_d  = pick_pg;
          used_we    = 1'b1;
          used_cnt_d = used_cnt_q + CNT_W'(1);
          if (recycle) begin
            head_d    = head_q + PAGE_W'(1);
            ret_cnt_d = ret_cnt_q - CNT_W'(1);
          end else begin
            created_d = created_q + CNT_W'(1);
          end
        end
        offset_d     = {1'b0, res_off} + size_q;
        out_page_d   = need_page ? pick_pg : last_pg_q;
        out_offset_d = res_off;
        out_new_d    = need_page;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= in_cmd_i;
      fence_q <= in_fence_i;
      size_q  <= in_size_i;
      align_q <= in_align_i;
    end
    last_pg_q    <= last_pg_d;
    rel_q        <= rel_d;
    out_status_q <= out_status_d;
    out_page_q   <= out_page_d;
    out_offset_q <= out_offset_d;
    out_new_q    <= out_new_d;
    out_rel_q    <= out_rel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      used_cnt_q  <= '0;
      head_q      <= '0;
      ret_cnt_q   <= '0;
      created_q   <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      offset_q    <= offset_d;
      used_cnt_q  <= used_cnt_d;
      head_q      <= head_d;
      ret_cnt_q   <= ret_cnt_d;
      created_q   <= created_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_page_o     = out_page_q;
  assign out_offset_o   = out_offset_q;
  assign out_new_o      = out_new_q;
  assign out_released_o = out_rel_q;

endmodule

// ----- sv/fenced_page_linear_allocator.sv -----
// ----------------------------------------------------------------------------
// fenced_page_linear_allocator
// Linear sub-allocator over 1 MiB pages with fence-gated page recycling.
// ----------------------------------------------------------------------------
// Channels: req_i carries a command (reserve or free), a fence value, a size
// and an alignment; rsp_o returns one result per command with status, page
// index, byte offset, a new-page flag and the count of pages released.
// A transfer happens on a clock edge with valid and ready both high.
// Reserve: the request transfer captures the command and reads the
// retired-page FIFO head from its RAM; the decision and update follow
// once the output register has room. Free: the used-page list is walked
// one entry per cycle through its RAM port into the retired-page FIFO.
// One command is in flight at a time; a new request is taken while the
// previous result still sits in the output register.
// Reset clears the offset, counters and FIFO pointers; page memories need no
// clearing. When the receiver stalls, the result holds in the output
// register and the command after it waits before its own result is written.
// ----------------------------------------------------------------------------
module fenced_page_linear_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpla_req_if.sink   req_i,
  fpla_rsp_if.source rsp_o
);
  import fpla_pkg::*;

  fpla_cmd_t cmd;
  fpla_sts_t sts;
  logic      in_ready;

  fpla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpla_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_cmd_i       (req_i.cmd),
    .in_fence_i     (req_i.fence_value),
    .in_size_i      (req_i.request_size),
    .in_align_i     (req_i.align_bytes),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .out_status_o   (rsp_o.status),
    .out_page_o     (rsp_o.page_index),
    .out_offset_o   (rsp_o.byte_offset),
    .out_new_o      (rsp_o.new_page),
    .out_released_o (rsp_o.released_count)
  );

  assign req_i.ready = in_ready;

endmodule

// ----- bench/alloc_result_checker.sv -----
// ----------------------------------------------------------------------------
// alloc_result_checker
// Watches the request and result channels of the fenced page allocator. It
// keeps its own copy of the offset, the used-page list and the retired-page
// FIFO, works out the result of every accepted command and compares each
// result transfer, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module alloc_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  fpla_req_if  req_i,
  fpla_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  import fpla_pkg::*;

  typedef struct {
    status_e           status;
    logic [PAGE_W-1:0] page_index;
    logic [OFF_W-1:0]  byte_offset;
    logic              new_page;
    logic [CNT_W-1:0]  released_count;
  } alloc_result_t;

  logic [63:0]        cur_offset;
  logic [PAGE_W-1:0]  used_pages [MAX_PAGES];
  logic [CNT_W-1:0]   used_cnt;
  logic [FENCE_W-1:0] retired_fence [MAX_PAGES];
  logic [PAGE_W-1:0]  retired_page [MAX_PAGES];
  logic [PAGE_W-1:0]  retire_head;
  logic [CNT_W-1:0]   retire_cnt;
  logic [CNT_W-1:0]   created_cnt;

  alloc_result_t owed_results[$];
  alloc_result_t oldest_result;
  int            fails;

  function automatic alloc_result_t predict_alloc(logic is_free, logic [FENCE_W-1:0] fence,
                                                  logic [SIZE_W-1:0] size,
                                                  logic [SIZE_W-1:0] align);
    alloc_result_t     r;
    logic [63:0]       a;
    logic [63:0]       aligned;
    logic [63:0]       offset;
    logic              need_page;
    logic              took;
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] tail;
    logic [CNT_W-1:0]  released;
    r.status         = STATUS_OK;
    r.page_index     = '0;
    r.byte_offset    = '0;
    r.new_page       = 1'b0;
    r.released_count = '0;
    if (is_free == CMD_FREE) begin
      released = '0;
      for (int i = 0; i < used_cnt; i++) begin
        if (retire_cnt < MAX_PAGES) begin
          tail                = retire_head + retire_cnt[PAGE_W-1:0];
          retired_fence[tail] = fence;
          retired_page[tail]  = used_pages[i];
          retire_cnt++;
          released++;
        end
      end
      used_cnt           = '0;
      cur_offset         = '0;
      r.released_count   = released;
      return r;
    end
    if (size >= PAGE_BYTES) begin
      r.status = STATUS_TOO_LARGE;
      return r;
    end
    a = {43'd0, align} & (~{43'd0, align} + 64'd1);
    if (a == 0) a = 64'd1;
    aligned   = (cur_offset + a - 64'd1) & ~(a - 64'd1);
    need_page = (used_cnt == 0) || (aligned >= PAGE_BYTES) ||
                ({43'd0, size} > PAGE_BYTES - aligned);
    offset    = aligned;
    took      = 1'b0;
    if (need_page) begin
      if (used_cnt >= MAX_PAGES) begin
        r.status = STATUS_NO_PAGE;
        return r;
      end
      if (retire_cnt > 0 && retired_fence[retire_head] < fence) begin
        pg = retired_page[retire_head];
        retire_head++;
        retire_cnt--;
      end else if (created_cnt < MAX_PAGES) begin
        pg = created_cnt[PAGE_W-1:0];
        created_cnt++;
      end else begin
        r.status = STATUS_NO_PAGE;
        return r;
      end
      used_pages[used_cnt[PAGE_W-1:0]] = pg;
      used_cnt++;
      offset = '0;
      took   = 1'b1;
    end
    cur_offset    = offset + {43'd0, size};
    r.page_index  = used_pages[used_cnt[PAGE_W-1:0] - 6'd1];
    r.byte_offset = offset[OFF_W-1:0];
    r.new_page    = took;
    return r;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_offset  = '0;
      used_cnt    = '0;
      retire_head = '0;
      retire_cnt  = '0;
      created_cnt = '0;
      fails       = 0;
      owed_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_results.size() == 0) begin
          $error("result transfer with no command owed: status %0d page %0d offset %0d",
                 rsp_i.status, rsp_i.page_index, rsp_i.byte_offset);
          fails++;
        end else begin
          oldest_result = owed_results.pop_front();
          check_field("status", oldest_result.status, rsp_i.status);
          check_field("page_index", oldest_result.page_index, rsp_i.page_index);
          check_field("byte_offset", oldest_result.byte_offset, rsp_i.byte_offset);
          check_field("new_page", oldest_result.new_page, rsp_i.new_page);
          check_field("released_count", oldest_result.released_count,
                      rsp_i.released_count);
        end
      end
      if (req_i.valid && req_i.ready) begin
        owed_results.insert(owed_results.size(),
                            predict_alloc(req_i.cmd, req_i.fence_value,
                                          req_i.request_size, req_i.align_bytes));
      end
      fail_count_o <= fails;
      pending_o    <= owed_results.size();
    end
  end

endmodule

// ----- bench/tb_fenced_page_linear_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_fenced_page_linear_allocator
// Drives reserve and free commands into the allocator: a directed opening
// over oversize requests, odd alignments, page-end overflow and fence-gated
// recycling, then random frames of reserves closed by a free, mixed with
// random commands. Both channels idle in random bursts; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fenced_page_linear_allocator;
  import fpla_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned CALM_ITEMS   = 150;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned PAUSE_AT     = 700;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam logic [FENCE_W-1:0] FENCE_MAX = '1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  int                 check_fails;
  int                 results_pending;
  int unsigned        sent = 0;
  int unsigned        total_items = '1;
  int unsigned        cycles = 0;
  int unsigned        idle_pct = 20;
  logic               calm = 1'b0;
  logic               hold_done = 1'b0;
  logic [FENCE_W-1:0] frame_fence = 64'd16;

  fpla_req_if req_ch ();
  fpla_rsp_if rsp_ch ();

  fenced_page_linear_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  alloc_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (check_fails),
    .pending_o    (results_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) return SIZE_W'($urandom_range(0, 64));
    else if (sel < 14) return SIZE_W'($urandom_range(0, 65535));
    else if (sel < 18) return SIZE_W'($urandom_range(0, PAGE_BYTES - 1));
    else if (sel < 19) return SIZE_W'($urandom_range(PAGE_BYTES, 2 * PAGE_BYTES - 1));
    else return SIZE_W'($urandom);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_align();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return SIZE_W'(1) << $urandom_range(0, SIZE_W - 1);
    else if (sel < 8) return '0;
    else return SIZE_W'($urandom);
  endfunction

  task automatic send_cmd(input logic c, input logic [FENCE_W-1:0] f,
                          input logic [SIZE_W-1:0] s, input logic [SIZE_W-1:0] a);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= c;
    req_ch.fence_value  <= f;
    req_ch.request_size <= s;
    req_ch.align_bytes  <= a;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent++;
    calm = (sent + CALM_ITEMS >= total_items);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold-off while commands keep coming
  initial begin
    rsp_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && sent >= HOLD_AT) begin
        hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned n;
    logic        big;
    logic        paused;
    paused              = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = CMD_RESERVE;
    req_ch.fence_value  = '0;
    req_ch.request_size = '0;
    req_ch.align_bytes  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(CMD_RESERVE, '0, '0, SIZE_W'(1));
    send_cmd(CMD_RESERVE, '0, SIZE_W'(PAGE_BYTES - 1), '0);
    send_cmd(CMD_RESERVE, '0, SIZE_W'(PAGE_BYTES), SIZE_W'(1));
    send_cmd(CMD_RESERVE, '0, '1, '1);
    send_cmd(CMD_RESERVE, '0, SIZE_W'(16), SIZE_W'(3));
    send_cmd(CMD_RESERVE, '0, SIZE_W'(100), SIZE_W'(PAGE_BYTES));
    send_cmd(CMD_RESERVE, '0, '0, '1);
    send_cmd(CMD_FREE, 64'd7, '0, '0);
    send_cmd(CMD_FREE, 64'd8, '1, '1);
    send_cmd(CMD_RESERVE, 64'd7, SIZE_W'(PAGE_BYTES / 2), SIZE_W'(16));
    send_cmd(CMD_RESERVE, 64'd8, SIZE_W'(PAGE_BYTES / 2), SIZE_W'(PAGE_BYTES / 2));
    send_cmd(CMD_RESERVE, 64'd8, '0, SIZE_W'(1));
    send_cmd(CMD_FREE, FENCE_MAX - 64'd1, '0, '0);
    repeat (5) send_cmd(CMD_RESERVE, FENCE_MAX, SIZE_W'(PAGE_BYTES - 1), SIZE_W'(1));
    send_cmd(CMD_FREE, '0, '0, '0);
    send_cmd(CMD_RESERVE, 64'd1, SIZE_W'(21'h12345), SIZE_W'(64));
    send_cmd(CMD_RESERVE, 64'd1, SIZE_W'(21'h0ABCD), SIZE_W'(21'h40000));
    send_cmd(CMD_FREE, 64'd9, '0, '0);

    total_items = sent + RANDOM_ITEMS;
    while (sent < total_items) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 1)
            send_cmd(CMD_FREE, frame_fence + $urandom_range(0, 3), pick_size(), pick_align());
          else
            send_cmd(CMD_RESERVE, {$urandom, $urandom}, SIZE_W'($urandom), SIZE_W'($urandom));
        end
      end else begin
        big = ($urandom_range(0, 29) == 0);
        n   = big ? $urandom_range(60, 72) : $urandom_range(1, 10);
        repeat (n) begin
          if (big)
            send_cmd(CMD_RESERVE, frame_fence,
                     SIZE_W'($urandom_range(PAGE_BYTES / 2 + 1, PAGE_BYTES - 1)), pick_align());
          else
            send_cmd(CMD_RESERVE, frame_fence, pick_size(), pick_align());
        end
        send_cmd(CMD_FREE, frame_fence, pick_size(), pick_align());
        frame_fence = frame_fence + $urandom_range(0, 2);
      end
      if (!paused && sent >= PAUSE_AT) begin
        paused = 1'b1;
        req_ch.valid <= 1'b0;
        wait_drained();
      end
    end

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (check_fails == 0 && results_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
